[rtl/core/motor_current_torque_model_top_defines.svh]
// ----------------------------------------------------------------------------
// Motor current/torque model: assertion macros
// Shared assertion wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef MOTOR_CURRENT_TORQUE_MODEL_TOP_DEFINES_SVH
`define MOTOR_CURRENT_TORQUE_MODEL_TOP_DEFINES_SVH

// Checked on every clock edge outside reset
`define MCTM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included
`define MCTM_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/mctm_pkg.sv]
// ----------------------------------------------------------------------------
// Motor current/torque model package
// Widths, constants and item types shared by the pipeline modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mctm_pkg;

   // Number format
   localparam int FRAC_BITS           = 16;
   localparam int SIGN_POLY_ORDER_DEF = 3;
   localparam int DW                  = 32;              // data fields
   localparam int KW                  = 31;              // coefficient registers
   localparam int SW                  = FRAC_BITS + 2;   // smoothed sign, signed
   localparam int PW                  = 2*DW - 1;        // coefficient times data
   localparam int TW                  = PW - FRAC_BITS + 1;
   localparam int NUM_W               = TW + 2;          // sum of four terms
   localparam int QW                  = DW + 1;          // quotient bits
   localparam int NW                  = NUM_W + FRAC_BITS + 1; // dividend
   localparam int IDX_W               = 3;

   // Pipeline depth per unit
   localparam int SIGN_STG  = 3;
   localparam int BLEND_STG = 2;
   localparam int TERM_STG  = 3;
   localparam int DIV_STG   = QW + 3;
   localparam int NSTG      = SIGN_STG + BLEND_STG + TERM_STG + DIV_STG;

   localparam int SIGN_TH_I = ((1 << FRAC_BITS) + 5) / 10;

   localparam logic signed [SW-1:0] S_ONE       = {2'b01, {FRAC_BITS{1'b0}}};
   localparam logic signed [SW-1:0] S_MONE      = -S_ONE;
   localparam logic signed [DW-1:0] SIGN_TH     = DW'(SIGN_TH_I);
   localparam logic signed [DW-1:0] SIGN_TH_NEG = -SIGN_TH;
   localparam logic signed [DW-1:0] OUT_MAX     = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] OUT_MIN     = {1'b1, {(DW-1){1'b0}}};
   localparam logic [KW-1:0]        GAIN_RESET  = {{(KW-FRAC_BITS-1){1'b0}}, 1'b1,
                                                   {FRAC_BITS{1'b0}}};

   // Opcodes
   localparam logic OP_TORQUE_TO_CURRENT = 1'b0;
   localparam logic OP_CURRENT_TO_TORQUE = 1'b1;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_TORQUE_GAIN_POS = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_TORQUE_GAIN_NEG = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_FRICTION_POS    = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_FRICTION_NEG    = IDX_W'(3);
   localparam logic [IDX_W-1:0] REG_VISCOUS_POS     = IDX_W'(4);
   localparam logic [IDX_W-1:0] REG_VISCOUS_NEG     = IDX_W'(5);
   localparam logic [IDX_W-1:0] REG_INERTIA_POS     = IDX_W'(6);
   localparam logic [IDX_W-1:0] REG_INERTIA_NEG     = IDX_W'(7);

   typedef struct packed {
      logic [KW-1:0] tgain_pos, tgain_neg;
      logic [KW-1:0] fric_pos, fric_neg;
      logic [KW-1:0] visc_pos, visc_neg;
      logic [KW-1:0] inert_pos, inert_neg;
   } cfg_type;

   typedef struct packed {
      logic                   op;
      logic signed [DW-1:0]   x, dq, ddq;
      logic signed [SW-1:0]   s;
   } sgn_type;

   typedef struct packed {
      logic                   op;
      logic signed [DW-1:0]   x, dq, ddq;
      logic signed [SW-1:0]   s;
      logic [KW-1:0]          kt, kf, kv, ka;
   } coef_type;

   typedef struct packed {
      logic                    op;
      logic signed [NUM_W-1:0] num;
      logic [KW-1:0]           kt;
   } num_type;

endpackage

`default_nettype wire

[rtl/core/mctm_sign.sv]
// ----------------------------------------------------------------------------
// Smoothed sign
// Three stages: scale and clamp velocity, square, cube and select.
// ----------------------------------------------------------------------------
`default_nettype none

module mctm_sign #(
   parameter int SIGN_POLY_ORDER = 3
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic                            in_op,
   input  logic signed [mctm_pkg::DW-1:0]  in_x,
   input  logic signed [mctm_pkg::DW-1:0]  in_dq,
   input  logic signed [mctm_pkg::DW-1:0]  in_ddq,
   output mctm_pkg::sgn_type               sgn_out
);
   import mctm_pkg::*;

   typedef struct packed {
      logic                 op;
      logic signed [DW-1:0] x, dq, ddq;
      logic                 gt, lt, vpos;
      logic signed [SW-1:0] a;
   } raw_type;

   localparam logic [2*SW-1:0] RND_HALF = (2*SW)'(1) << (FRAC_BITS - 1);

   raw_type                raw1_in, raw1_ff, raw2_ff;
   logic signed [SW-1:0]   a2_in, a2_ff;
   logic signed [SW-1:0]   v_n;
   logic signed [SW+3:0]   v_x, a_w;
   logic signed [2*SW-1:0] sq;
   logic [SW-1:0]          mag_a, a3m;
   logic [2*SW-1:0]        cu;
   logic signed [SW-1:0]   a3, shaped;
   sgn_type                sgn_in, sgn_ff;

   // Stage 1: threshold compare, a = 10*velocity clamped to +-1
   always_comb begin
      v_n          = in_dq[SW-1:0];
      v_x          = (SW+4)'(v_n);
      a_w          = (v_x <<< 3) + (v_x <<< 1);
      raw1_in.op   = in_op;
      raw1_in.x    = in_x;
      raw1_in.dq   = in_dq;
      raw1_in.ddq  = in_ddq;
      raw1_in.gt   = in_dq > SIGN_TH;
      raw1_in.lt   = in_dq < SIGN_TH_NEG;
      raw1_in.vpos = in_dq > 0;
      if (a_w > (SW+4)'(S_ONE)) begin
         raw1_in.a = S_ONE;
      end else if (a_w < (SW+4)'(S_MONE)) begin
         raw1_in.a = S_MONE;
      end else begin
         raw1_in.a = a_w[SW-1:0];
      end
   end

   // Stage 2: a^2 rounded
   always_comb begin
      sq    = (2*SW)'(raw1_ff.a) * (2*SW)'(raw1_ff.a);
      a2_in = SW'(($unsigned(sq) + RND_HALF) >> FRAC_BITS);
   end

   // Stage 3: a^3 rounded, shape by order, saturate beyond threshold
   always_comb begin
      mag_a = raw2_ff.a[SW-1] ? SW'(-raw2_ff.a) : SW'(raw2_ff.a);
      cu    = (2*SW)'($unsigned(a2_ff)) * (2*SW)'(mag_a);
      a3m   = SW'((cu + RND_HALF) >> FRAC_BITS);
      a3    = raw2_ff.a[SW-1] ? -$signed(a3m) : $signed(a3m);
      if (SIGN_POLY_ORDER == 1) begin
         shaped = raw2_ff.a;
      end else if (SIGN_POLY_ORDER == 2) begin
         shaped = raw2_ff.vpos ? a2_ff : -a2_ff;
      end else begin
         shaped = a3;
      end
      sgn_in.op  = raw2_ff.op;
      sgn_in.x   = raw2_ff.x;
      sgn_in.dq  = raw2_ff.dq;
      sgn_in.ddq = raw2_ff.ddq;
      priority if (raw2_ff.gt) begin
         sgn_in.s = S_ONE;
      end else if (raw2_ff.lt) begin
         sgn_in.s = S_MONE;
      end else begin
         sgn_in.s = shaped;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         raw1_ff <= raw1_in;
         raw2_ff <= raw1_ff;
         a2_ff   <= a2_in;
         sgn_ff  <= sgn_in;
      end
   end

   assign sgn_out = sgn_ff;

endmodule

`default_nettype wire

[rtl/core/mctm_blend.sv]
// ----------------------------------------------------------------------------
// Coefficient blend
// K = (Kp*(1+s) + Kn*(1-s)) / 2, rounded; products then sum and round.
// ----------------------------------------------------------------------------
`default_nettype none

module mctm_blend (
   input  logic               clock,
   input  logic               en,
   input  mctm_pkg::cfg_type  cfg,
   input  mctm_pkg::sgn_type  sgn_in,
   output mctm_pkg::coef_type coef_out
);
   import mctm_pkg::*;

   localparam int BPW = KW + SW;
   localparam logic [BPW:0] BLEND_HALF = (BPW+1)'(1) << FRAC_BITS;

   logic [KW-1:0]  kp [4];
   logic [KW-1:0]  kn [4];
   logic [SW-1:0]  wp, wn;
   logic [BPW-1:0] pp_in [4];
   logic [BPW-1:0] pn_in [4];
   logic [BPW-1:0] pp_ff [4];
   logic [BPW-1:0] pn_ff [4];
   logic [BPW:0]   bsum [4];
   logic [KW-1:0]  k [4];
   sgn_type        sgn_ff;
   coef_type       coef_in, coef_ff;

   // Stage 1: weights and the eight products
   always_comb begin
      kp[0] = cfg.tgain_pos;  kn[0] = cfg.tgain_neg;
      kp[1] = cfg.fric_pos;   kn[1] = cfg.fric_neg;
      kp[2] = cfg.visc_pos;   kn[2] = cfg.visc_neg;
      kp[3] = cfg.inert_pos;  kn[3] = cfg.inert_neg;
      wp    = $unsigned(S_ONE + sgn_in.s);
      wn    = $unsigned(S_ONE - sgn_in.s);
      for (int i = 0; i < 4; i++) begin
         pp_in[i] = BPW'(kp[i]) * BPW'(wp);
         pn_in[i] = BPW'(kn[i]) * BPW'(wn);
      end
   end

   // Stage 2: sum and round by 2^(F+1)
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         bsum[i] = (BPW+1)'(pp_ff[i]) + (BPW+1)'(pn_ff[i]);
         k[i]    = KW'((bsum[i] + BLEND_HALF) >> (FRAC_BITS + 1));
      end
      coef_in.op  = sgn_ff.op;
      coef_in.x   = sgn_ff.x;
      coef_in.dq  = sgn_ff.dq;
      coef_in.ddq = sgn_ff.ddq;
      coef_in.s   = sgn_ff.s;
      coef_in.kt  = k[0];
      coef_in.kf  = k[1];
      coef_in.kv  = k[2];
      coef_in.ka  = k[3];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff   <= pp_in;
         pn_ff   <= pn_in;
         sgn_ff  <= sgn_in;
         coef_ff <= coef_in;
      end
   end

   assign coef_out = coef_ff;

endmodule

`default_nettype wire

[rtl/core/mctm_terms.sv]
// ----------------------------------------------------------------------------
// Model terms
// Four coefficient products, rounding, and the sum per opcode.
// ----------------------------------------------------------------------------
`default_nettype none

module mctm_terms (
   input  logic               clock,
   input  logic               en,
   input  mctm_pkg::coef_type coef_in,
   output mctm_pkg::num_type  num_out
);
   import mctm_pkg::*;

   localparam logic [PW-1:0] TERM_HALF = PW'(1) << (FRAC_BITS - 1);

   logic [KW-1:0]          ks [4];
   logic signed [DW-1:0]   xs [4];
   logic signed [PW-1:0]   p_in [4];
   logic signed [PW-1:0]   p_ff [4];
   logic [PW-1:0]          pm [4];
   logic [PW-1:0]          pr [4];
   logic signed [TW-1:0]   t_in [4];
   logic signed [TW-1:0]   t_ff [4];
   logic                   op6_ff, op7_ff;
   logic signed [DW-1:0]   x6_ff, x7_ff;
   logic [KW-1:0]          kt6_ff, kt7_ff;
   num_type                num_in, num_ff;

   // Stage 1: Kt*x, Kv*dq, Ka*ddq, Kf*s
   always_comb begin
      ks[0] = coef_in.kt;  xs[0] = coef_in.x;
      ks[1] = coef_in.kv;  xs[1] = coef_in.dq;
      ks[2] = coef_in.ka;  xs[2] = coef_in.ddq;
      ks[3] = coef_in.kf;  xs[3] = DW'(coef_in.s);
      for (int i = 0; i < 4; i++) begin
         p_in[i] = PW'($signed({1'b0, ks[i]})) * PW'(xs[i]);
      end
   end

   // Stage 2: round each product, ties away from zero
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pm[i]   = p_ff[i][PW-1] ? $unsigned(-p_ff[i]) : $unsigned(p_ff[i]);
         pr[i]   = (pm[i] + TERM_HALF) >> FRAC_BITS;
         t_in[i] = p_ff[i][PW-1] ? -$signed(TW'(pr[i])) : $signed(TW'(pr[i]));
      end
   end

   // Stage 3: current = sum of terms, or numerator = x minus load terms
   always_comb begin
      num_in.op = op7_ff;
      num_in.kt = kt7_ff;
      if (op7_ff == OP_TORQUE_TO_CURRENT) begin
         num_in.num = NUM_W'(t_ff[0]) + NUM_W'(t_ff[1]) + NUM_W'(t_ff[2])
                    + NUM_W'(t_ff[3]);
      end else begin
         num_in.num = NUM_W'(x7_ff) - NUM_W'(t_ff[1]) - NUM_W'(t_ff[2])
                    - NUM_W'(t_ff[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         op6_ff <= coef_in.op;
         x6_ff  <= coef_in.x;
         kt6_ff <= coef_in.kt;
         t_ff   <= t_in;
         op7_ff <= op6_ff;
         x7_ff  <= x6_ff;
         kt7_ff <= kt6_ff;
         num_ff <= num_in;
      end
   end

   assign num_out = num_ff;

endmodule

`default_nettype wire

[rtl/core/mctm_div.sv]
// ----------------------------------------------------------------------------
// Divider and output stage
// Saturation for current results; restoring division, one quotient bit per
// stage, for torque results; final select into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mctm_div (
   input  logic                            clock,
   input  logic                            en,
   input  mctm_pkg::num_type               num_in,
   output logic signed [mctm_pkg::DW-1:0]  model_value,
   output logic                            saturated
);
   import mctm_pkg::*;

   localparam int RW = NW - QW;
   localparam logic [QW-1:0] NEG_LIM = {2'b01, {(DW-1){1'b0}}};
   localparam logic [QW-1:0] POS_LIM = {2'b00, {(DW-1){1'b1}}};

   typedef struct packed {
      logic                 done;   // result already settled
      logic                 neg;
      logic [NUM_W-1:0]     mag;
      logic [KW-1:0]        den;
      logic signed [DW-1:0] fval;
      logic                 fsat;
   } prep_type;

   typedef struct packed {
      logic                 done;
      logic                 neg;
      logic                 ovf;
      logic signed [DW-1:0] fval;
      logic                 fsat;
      logic [KW-1:0]        den;
      logic [KW-1:0]        rem;
      logic [QW-1:0]        low;
      logic [QW-1:0]        quo;
   } div_type;

   prep_type             p1_in, p1_ff;
   div_type              d0_in;
   div_type              dv_ff [QW+1];
   logic [NW-1:0]        dvd;
   logic [RW-1:0]        r0;
   logic [QW-1:0]        qf;
   logic signed [DW-1:0] val_in, val_ff;
   logic                 sat_in, sat_ff;

   // Prep 1: magnitude, zero divisor and current result saturation
   always_comb begin
      p1_in.neg = num_in.num < 0;
      p1_in.mag = p1_in.neg ? $unsigned(-num_in.num) : $unsigned(num_in.num);
      p1_in.den = num_in.kt;
      p1_in.done = (num_in.op == OP_TORQUE_TO_CURRENT) || (num_in.kt == '0);
      if (num_in.op == OP_TORQUE_TO_CURRENT) begin
         if (num_in.num > NUM_W'(OUT_MAX)) begin
            p1_in.fval = OUT_MAX;
            p1_in.fsat = 1'b1;
         end else if (num_in.num < NUM_W'(OUT_MIN)) begin
            p1_in.fval = OUT_MIN;
            p1_in.fsat = 1'b1;
         end else begin
            p1_in.fval = num_in.num[DW-1:0];
            p1_in.fsat = 1'b0;
         end
      end else begin
         // zero torque constant: limit by the sign of the numerator
         p1_in.fsat = 1'b1;
         if (num_in.num > 0) begin
            p1_in.fval = OUT_MAX;
         end else if (p1_in.neg) begin
            p1_in.fval = OUT_MIN;
         end else begin
            p1_in.fval = '0;
         end
      end
   end

   // Prep 2: dividend = mag*2^F + den/2, early overflow check
   always_comb begin
      dvd        = {1'b0, p1_ff.mag, {FRAC_BITS{1'b0}}} + NW'(p1_ff.den >> 1);
      r0         = dvd[NW-1:QW];
      d0_in.done = p1_ff.done;
      d0_in.neg  = p1_ff.neg;
      d0_in.ovf  = r0 >= RW'(p1_ff.den);
      d0_in.fval = p1_ff.fval;
      d0_in.fsat = p1_ff.fsat;
      d0_in.den  = p1_ff.den;
      d0_in.rem  = r0[KW-1:0];
      d0_in.low  = dvd[QW-1:0];
      d0_in.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= p1_in;
         dv_ff[0] <= d0_in;
      end
   end

   // One quotient bit per stage
   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [KW:0] r2;
      logic        ge;
      div_type     nx;

      always_comb begin
         r2     = {dv_ff[i].rem, dv_ff[i].low[QW-1]};
         ge     = r2 >= {1'b0, dv_ff[i].den};
         nx     = dv_ff[i];
         nx.rem = ge ? KW'(r2 - {1'b0, dv_ff[i].den}) : r2[KW-1:0];
         nx.low = dv_ff[i].low << 1;
         nx.quo = {dv_ff[i].quo[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[i+1] <= nx;
         end
      end
   end

   // Output select and saturation
   always_comb begin
      qf = dv_ff[QW].quo;
      priority if (dv_ff[QW].done) begin
         val_in = dv_ff[QW].fval;
         sat_in = dv_ff[QW].fsat;
      end else if (dv_ff[QW].ovf) begin
         val_in = dv_ff[QW].neg ? OUT_MIN : OUT_MAX;
         sat_in = 1'b1;
      end else if (dv_ff[QW].neg) begin
         sat_in = qf > NEG_LIM;
         val_in = sat_in ? OUT_MIN : $signed(DW'(0) - qf[DW-1:0]);
      end else begin
         sat_in = qf > POS_LIM;
         val_in = sat_in ? OUT_MAX : $signed(qf[DW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         val_ff <= val_in;
         sat_ff <= sat_in;
      end
   end

   assign model_value = val_ff;
   assign saturated   = sat_ff;

endmodule

`default_nettype wire

[rtl/core/motor_current_torque_model_top.sv]
// ----------------------------------------------------------------------------
// Motor current/torque model, top level
// Q16.16 motor model with a blended, smoothed-sign friction law.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+-----------
//  req     | valid, stall, opcode, drive_value, velocity,  | in
//          | acceleration                                 |
//  rsp     | valid, stall, model_value, saturated         | out
//  csr     | wr_en, index, wdata                          | in
//
//  One item enters per cycle while the pipeline is not stalled. Pipeline stages
//  (Q16.16 widths): sign 3, blend 2, terms 3, divider prep 2, one quotient
//  bit per stage 33, output 1. The divider chain sets the latency.
//  Reset is synchronous; it empties the pipeline and loads register defaults.
//  A stalled result freezes the whole pipeline; req_stall follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_current_torque_model_top #(
   parameter int SIGN_POLY_ORDER = mctm_pkg::SIGN_POLY_ORDER_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic signed [mctm_pkg::DW-1:0]     req_drive_value,
   input  logic signed [mctm_pkg::DW-1:0]     req_velocity,
   input  logic signed [mctm_pkg::DW-1:0]     req_acceleration,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [mctm_pkg::DW-1:0]     rsp_model_value,
   output logic                               rsp_saturated,
   input  logic                               csr_wr_en,
   input  logic [mctm_pkg::IDX_W-1:0]         csr_index,
   input  logic [mctm_pkg::KW-1:0]            csr_wdata
);
   import mctm_pkg::*;

   cfg_type          cfg_ff;
   logic [NSTG-1:0]  vld_ff;
   logic             en;
   sgn_type          sgn;
   coef_type         coef;
   num_type          num;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{tgain_pos: GAIN_RESET, tgain_neg: GAIN_RESET, default: '0};
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_TORQUE_GAIN_POS: cfg_ff.tgain_pos <= csr_wdata;
            REG_TORQUE_GAIN_NEG: cfg_ff.tgain_neg <= csr_wdata;
            REG_FRICTION_POS:    cfg_ff.fric_pos  <= csr_wdata;
            REG_FRICTION_NEG:    cfg_ff.fric_neg  <= csr_wdata;
            REG_VISCOUS_POS:     cfg_ff.visc_pos  <= csr_wdata;
            REG_VISCOUS_NEG:     cfg_ff.visc_neg  <= csr_wdata;
            REG_INERTIA_POS:     cfg_ff.inert_pos <= csr_wdata;
            REG_INERTIA_NEG:     cfg_ff.inert_neg <= csr_wdata;
         endcase
      end
   end

   // Pipeline advance and valid bits
   assign en        = !vld_ff[NSTG-1] || !rsp_stall;
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req_valid};
      end
   end

   mctm_sign #(
      .SIGN_POLY_ORDER (SIGN_POLY_ORDER)
   ) u_sign (
      .clock   (clock),
      .en      (en),
      .in_op   (req_opcode),
      .in_x    (req_drive_value),
      .in_dq   (req_velocity),
      .in_ddq  (req_acceleration),
      .sgn_out (sgn)
   );

   mctm_blend u_blend (
      .clock    (clock),
      .en       (en),
      .cfg      (cfg_ff),
      .sgn_in   (sgn),
      .coef_out (coef)
   );

   mctm_terms u_terms (
      .clock   (clock),
      .en      (en),
      .coef_in (coef),
      .num_out (num)
   );

   mctm_div u_div (
      .clock       (clock),
      .en          (en),
      .num_in      (num),
      .model_value (rsp_model_value),
      .saturated   (rsp_saturated)
   );

   assign rsp_valid = vld_ff[NSTG-1];

endmodule

`default_nettype wire

[rtl/core/mctm_port_check.sv]
// ----------------------------------------------------------------------------
// Motor current/torque model port checker
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_current_torque_model_top_defines.svh"

module mctm_port_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_stall,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [mctm_pkg::DW-1:0]     rsp_model_value,
   input  logic                               rsp_saturated
);
   import mctm_pkg::*;

   // a held result stays put
   `MCTM_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_model_value) && $stable(rsp_saturated), "rsp item changed while stalled")

   // reset empties the pipeline
   `MCTM_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid, "rsp_valid after reset")

   // input only stalls behind a stalled result
   `MCTM_ASSERT(a_stall_cause, !rsp_valid || !rsp_stall |-> !req_stall, "req stalled without held result")

   // a clipped result sits at a limit, or zero for a zero torque constant
   `MCTM_ASSERT(a_sat_value, rsp_valid && rsp_saturated |-> rsp_model_value == OUT_MAX || rsp_model_value == OUT_MIN || rsp_model_value == '0, "saturated value off limit")

endmodule

bind motor_current_torque_model_top mctm_port_check u_port_check (.*);

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Motor current/torque model testbench
// Drives random and corner items through the pipeline under bursty input and
// a stalling output, predicts every result in fixed point and checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import mctm_pkg::*;

   localparam int     POLY_ORDER = SIGN_POLY_ORDER_DEF;
   localparam longint FX_ONE     = 64'sd1 <<< FRAC_BITS;
   localparam longint VEL_TH     = (FX_ONE + 5) / 10;
   localparam longint LIM_HI     = 64'sd2147483647;
   localparam longint LIM_LO     = -64'sd2147483648;
   localparam int     DRAIN_CYC  = 60;
   localparam int     LONG_HOLD  = 300;

   typedef struct {
      logic              op;
      logic signed [31:0] drive;
      logic signed [31:0] vel;
      logic signed [31:0] accel;
   } motor_item_type;

   typedef struct {
      logic signed [31:0] value;
      logic               sat;
   } model_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_opcode       = OP_TORQUE_TO_CURRENT;
   logic signed [31:0] req_drive_value  = '0;
   logic signed [31:0] req_velocity     = '0;
   logic signed [31:0] req_acceleration = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [31:0] rsp_model_value;
   logic               rsp_saturated;
   logic               csr_wr_en        = 1'b0;
   logic [IDX_W-1:0]   csr_index        = '0;
   logic [KW-1:0]      csr_wdata        = '0;

   // coefficient shadow, indexed by register index
   logic [KW-1:0] coef [8];

   // velocities around zero and around the smoothing threshold
   logic [31:0] mk_vel_list [10] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'd6553, 32'd6554,
                                     32'd6555, -32'sd6553, -32'sd6554, -32'sd6555,
                                     32'h0000_0CCD};

   motor_item_type pending_items [$];
   model_out_type  expected_out  [$];

   int  err_cnt      = 0;
   int  accept_cnt   = 0;
   int  burst_left   = 0;
   int  gap_left     = 0;
   bit  gappy_sender = 1'b0;
   int  stall_mode   = 0;
   int  hold_cnt     = 0;
   bit  hold_done    = 1'b0;
   int  cyc          = 0;

   motor_current_torque_model_top #(.SIGN_POLY_ORDER(POLY_ORDER)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_drive_value  (req_drive_value),
      .req_velocity     (req_velocity),
      .req_acceleration (req_acceleration),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_model_value  (rsp_model_value),
      .rsp_saturated    (rsp_saturated),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model
   // divide by 2^sh, round to nearest, ties away from zero
   function automatic longint round_shift(longint x, int sh);
      longint unsigned m;
      m = (x < 0) ? longint'(-x) : longint'(x);
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (x < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint smooth_sign(longint v);
      longint a, a2;
      if (v > VEL_TH) return FX_ONE;
      if (v < -VEL_TH) return -FX_ONE;
      a = v * 10;
      if (a > FX_ONE) a = FX_ONE;
      if (a < -FX_ONE) a = -FX_ONE;
      if (POLY_ORDER == 1) return a;
      a2 = round_shift(a * a, FRAC_BITS);
      if (POLY_ORDER == 2) return (v > 0) ? a2 : -a2;
      return round_shift(a2 * a, FRAC_BITS);
   endfunction

   function automatic longint blend_coef(logic [KW-1:0] kp, logic [KW-1:0] kn, longint s);
      longint sum;
      sum = longint'(kp) * (FX_ONE + s) + longint'(kn) * (FX_ONE - s);
      return round_shift(sum, FRAC_BITS + 1);
   endfunction

   function automatic longint qmul(longint k, longint x);
      return round_shift(k * x, FRAC_BITS);
   endfunction

   function automatic model_out_type predict_motor(motor_item_type it);
      model_out_type  o;
      longint         x, dq, ddq, s, kt, kf, kv, ka, res, num;
      longint unsigned m, d, q, r, mag;
      x   = longint'(it.drive);
      dq  = longint'(it.vel);
      ddq = longint'(it.accel);
      s   = smooth_sign(dq);
      kt  = blend_coef(coef[REG_TORQUE_GAIN_POS], coef[REG_TORQUE_GAIN_NEG], s);
      kf  = blend_coef(coef[REG_FRICTION_POS], coef[REG_FRICTION_NEG], s);
      kv  = blend_coef(coef[REG_VISCOUS_POS], coef[REG_VISCOUS_NEG], s);
      ka  = blend_coef(coef[REG_INERTIA_POS], coef[REG_INERTIA_NEG], s);
      o.sat = 1'b0;
      if (it.op == OP_TORQUE_TO_CURRENT) begin
         res = qmul(kt, x) + qmul(kv, dq) + qmul(ka, ddq) + qmul(kf, s);
      end else begin
         num = x - qmul(kv, dq) - qmul(ka, ddq) - qmul(kf, s);
         if (kt == 0) begin
            // zero torque constant: pin to the sign of the numerator
            res   = (num > 0) ? LIM_HI + 1 : ((num < 0) ? LIM_LO - 1 : 0);
            o.sat = 1'b1;
         end else begin
            m = (num < 0) ? longint'(-num) : longint'(num);
            d = longint'(kt);
            q = m / d;
            r = m % d;
            if (q > (64'd1 << (32 - FRAC_BITS))) begin
               res = (num < 0) ? LIM_LO - 1 : LIM_HI + 1;
            end else begin
               mag = (q << FRAC_BITS) + (((r << FRAC_BITS) + d / 2) / d);
               res = (num < 0) ? -longint'(mag) : longint'(mag);
            end
         end
      end
      if (res > LIM_HI) begin
         res   = LIM_HI;
         o.sat = 1'b1;
      end
      if (res < LIM_LO) begin
         res   = LIM_LO;
         o.sat = 1'b1;
      end
      o.value = res[31:0];
      return o;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic logic [31:0] pick_field();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 13108)) - 6554);
         2: return 32'($signed($urandom_range(0, 1400)) - 700);
         3: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               default: return 32'h1;
            endcase
         end
         default: return 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
      endcase
   endfunction

   function automatic motor_item_type rand_item();
      motor_item_type it;
      it.op    = $urandom_range(0, 1) ? OP_CURRENT_TO_TORQUE : OP_TORQUE_TO_CURRENT;
      it.drive = pick_field();
      it.vel   = pick_field();
      it.accel = pick_field();
      return it;
   endfunction

   function automatic motor_item_type mk_item(logic op, logic [31:0] x, logic [31:0] v,
                                              logic [31:0] a);
      motor_item_type it;
      it.op    = op;
      it.drive = x;
      it.vel   = v;
      it.accel = a;
      return it;
   endfunction

   task automatic write_coef(logic [IDX_W-1:0] idx, logic [KW-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      coef[idx] = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait until the pipeline has delivered every predicted result
   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_out.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_coefs();
      int i;
      for (i = 0; i < 8; i++) begin
         if (i < 2)
            write_coef(IDX_W'(i), $urandom_range(0, 1) ? KW'($urandom_range(1, 1 << 18))
                                                       : KW'($urandom | 1));
         else
            write_coef(IDX_W'(i), $urandom_range(0, 2) ? KW'($urandom_range(0, 1 << 17))
                                                       : KW'($urandom));
      end
   endtask

   task automatic run_random(int n);
      int i;
      for (i = 0; i < n; i++) pending_items.push_back(rand_item());
      drain();
   endtask

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      logic           take;
      motor_item_type it;
      take = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            it.op    = req_opcode;
            it.drive = req_drive_value;
            it.vel   = req_velocity;
            it.accel = req_acceleration;
            expected_out.push_back(predict_motor(it));
            accept_cnt++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() != 0) begin
               take = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 20);
                  gap_left   = gappy_sender ? $urandom_range(0, 6) : 0;
               end
            end
            if (take) begin
               it = pending_items.pop_front();
               req_opcode       <= it.op;
               req_drive_value  <= it.drive;
               req_velocity     <= it.vel;
               req_acceleration <= it.accel;
            end
            req_valid <= take;
         end
      end
   end

   // ---------------------------------------------------------------- receiver stall
   always @(posedge clock) begin
      logic st;
      cyc++;
      st = 1'b0;
      if (hold_cnt > 0) begin
         hold_cnt--;
         st = 1'b1;
      end else if (!hold_done && accept_cnt >= 400) begin
         // one long hold-off so the pipeline backs up into the input
         hold_done = 1'b1;
         hold_cnt  = LONG_HOLD;
         st        = 1'b1;
      end else begin
         case (stall_mode)
            1:       st = ($urandom_range(0, 3) == 0);
            2:       st = ((cyc % 7) < 3);
            3:       st = ($urandom_range(0, 1) == 0);
            default: st = 1'b0;
         endcase
      end
      rsp_stall <= st;
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      model_out_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_out.size() == 0) begin
            $display("%0t: unexpected result value=%h sat=%b", $time, rsp_model_value,
                     rsp_saturated);
            err_cnt++;
         end else begin
            e = expected_out.pop_front();
            if (rsp_model_value !== e.value) begin
               $display("%0t: model_value expected %h actual %h", $time, e.value,
                        rsp_model_value);
               err_cnt++;
            end
            if (rsp_saturated !== e.sat) begin
               $display("%0t: saturated expected %b actual %b", $time, e.sat,
                        rsp_saturated);
               err_cnt++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      int i;
      coef[REG_TORQUE_GAIN_POS] = GAIN_RESET;
      coef[REG_TORQUE_GAIN_NEG] = GAIN_RESET;
      for (i = 2; i < 8; i++) coef[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners under reset coefficients, then with asymmetric ones
      stall_mode = 0;
      pending_items.push_back(mk_item(OP_TORQUE_TO_CURRENT, 32'h0001_0000, 32'h0, 32'h0));
      pending_items.push_back(mk_item(OP_CURRENT_TO_TORQUE, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'h7FFF_FFFF));
      drain();
      write_coef(REG_TORQUE_GAIN_POS, 31'h0002_0000);
      write_coef(REG_TORQUE_GAIN_NEG, 31'h0000_8000);
      write_coef(REG_FRICTION_POS, 31'h0000_4000);
      write_coef(REG_FRICTION_NEG, 31'h0000_C000);
      write_coef(REG_VISCOUS_POS, 31'h0000_2000);
      write_coef(REG_VISCOUS_NEG, 31'h0001_0000);
      write_coef(REG_INERTIA_POS, 31'h0000_0100);
      write_coef(REG_INERTIA_NEG, 31'h0000_3000);
      foreach (mk_vel_list[vi]) begin
         pending_items.push_back(mk_item(OP_TORQUE_TO_CURRENT, 32'h0003_0000,
                                         mk_vel_list[vi], 32'h0000_8000));
         pending_items.push_back(mk_item(OP_CURRENT_TO_TORQUE, 32'hFFFD_0000,
                                         mk_vel_list[vi], 32'hFFFF_8000));
      end
      pending_items.push_back(mk_item(OP_TORQUE_TO_CURRENT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF));
      pending_items.push_back(mk_item(OP_TORQUE_TO_CURRENT, 32'h8000_0000, 32'h8000_0000,
                                      32'h8000_0000));
      pending_items.push_back(mk_item(OP_CURRENT_TO_TORQUE, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'h8000_0000));
      drain();

      // random phases, each under new coefficients and flow-control style
      gappy_sender = 1'b1;
      stall_mode   = 1;
      random_coefs();
      run_random(220);
      stall_mode   = 2;
      random_coefs();
      run_random(200);
      gappy_sender = 1'b0;
      stall_mode   = 0;
      random_coefs();
      run_random(150);

      // largest coefficients
      stall_mode = 3;
      for (i = 0; i < 8; i++) write_coef(IDX_W'(i), 31'h7FFF_FFFF);
      run_random(100);

      // smallest coefficients
      gappy_sender = 1'b1;
      stall_mode   = 1;
      for (i = 0; i < 8; i++) write_coef(IDX_W'(i), (i < 2) ? 31'h1 : 31'h0);
      run_random(100);

      // zero torque constant on both sides
      write_coef(REG_TORQUE_GAIN_POS, 31'h0);
      write_coef(REG_TORQUE_GAIN_NEG, 31'h0);
      write_coef(REG_VISCOUS_POS, 31'h0001_0000);
      pending_items.push_back(mk_item(OP_CURRENT_TO_TORQUE, 32'h0, 32'h0, 32'h0));
      pending_items.push_back(mk_item(OP_CURRENT_TO_TORQUE, 32'h0001_0000, 32'h0, 32'h0));
      pending_items.push_back(mk_item(OP_CURRENT_TO_TORQUE, 32'hFFFF_0000, 32'h0, 32'h0));
      run_random(80);

      stall_mode = 2;
      random_coefs();
      run_random(150);

      repeat (DRAIN_CYC) @(posedge clock);
      if (err_cnt == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
